@@ design/smf_pkg.sv @@
package smf_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_W      = 5;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int BIT_W      = $clog2(SAMPLE_W);
	localparam int GRP_W      = 4;
	localparam int GRP_N      = (MAX_WINDOW + GRP_W - 1) / GRP_W;
	localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(16);

	typedef logic [MAX_WINDOW-1:0] lane_mask_t;

	// two-level count: small groups first, then the group sums
	function automatic logic [CNT_W-1:0] count_ones(input lane_mask_t v);
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] grp;
		total = '0;
		for (int g = 0; g < GRP_N; g++) begin
			grp = '0;
			for (int b = 0; b < GRP_W; b++) begin
				if (g * GRP_W + b < MAX_WINDOW) begin
					grp = grp + CNT_W'(v[g * GRP_W + b]);
				end
			end
			total = total + grp;
		end
		return total;
	endfunction

endpackage

@@ design/sliding_median_filter_unit.sv @@
// Running median over the last window_length signed samples (1..16, reset 16;
// 0 acts as 1, larger values as 16). Each accepted request is written into the
// window and the element at rank count/2 of the stored samples is returned,
// the upper median for an even count; a window still filling uses only the
// samples seen so far. The rank is found bit-serially, MSB first, one result
// bit per cycle across all stored samples; the result is then loaded into the
// output register, and no new request is taken until that is done. The output
// register lets the next request enter while a result waits. A write of
// window_length clears the window unless a request is accepted in the same
// cycle; the user must write it only while idle: the block does not enforce it.
module sliding_median_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [smf_pkg::SAMPLE_W-1:0] sample_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [smf_pkg::SAMPLE_W-1:0] median_out,
	input  logic                              cfg_wr_en,
	input  logic        [smf_pkg::CFG_W-1:0]    cfg_wr_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                           state_q;
	logic [smf_pkg::CFG_W-1:0]        win_q;
	logic [smf_pkg::IDX_W-1:0]        wr_pos_q;
	logic [smf_pkg::CNT_W-1:0]        fill_q;
	logic [smf_pkg::SAMPLE_W-1:0]     store_q [smf_pkg::MAX_WINDOW];
	smf_pkg::lane_mask_t              mask_q;
	logic [smf_pkg::CNT_W-1:0]        rank_q;
	logic [smf_pkg::BIT_W-1:0]        bit_q;
	logic [smf_pkg::SAMPLE_W-1:0]     res_q;
	logic                             out_valid_q;
	logic [smf_pkg::SAMPLE_W-1:0]     median_q;

	logic [smf_pkg::CNT_W-1:0]        eff_win;
	logic [smf_pkg::IDX_W-1:0]        pos_use;
	logic [smf_pkg::CNT_W-1:0]        pos_inc;
	logic [smf_pkg::IDX_W-1:0]        pos_next;
	logic [smf_pkg::CNT_W-1:0]        fill_next;
	smf_pkg::lane_mask_t              mask_init;
	smf_pkg::lane_mask_t              col;
	smf_pkg::lane_mask_t              zeros;
	logic [smf_pkg::CNT_W-1:0]        zero_cnt;
	logic                             msb;
	logic                             take0;
	logic                             accept;
	logic                             out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (win_q == '0) begin
			eff_win = smf_pkg::CNT_W'(1);
		end else if (32'(win_q) > smf_pkg::MAX_WINDOW) begin
			eff_win = smf_pkg::CNT_W'(smf_pkg::MAX_WINDOW);
		end else begin
			eff_win = smf_pkg::CNT_W'(win_q);
		end
		pos_use  = (smf_pkg::CNT_W'(wr_pos_q) >= eff_win) ? '0 : wr_pos_q;
		pos_inc  = smf_pkg::CNT_W'(pos_use) + smf_pkg::CNT_W'(1);
		pos_next = (pos_inc >= eff_win) ? '0 : pos_inc[smf_pkg::IDX_W-1:0];
		fill_next = (fill_q < eff_win) ? fill_q + smf_pkg::CNT_W'(1) : eff_win;
		for (int i = 0; i < smf_pkg::MAX_WINDOW; i++) begin
			mask_init[i] = (smf_pkg::CNT_W'(i) < fill_next);
		end
	end

	// sign bit is inverted so that unsigned ranking gives signed order
	always_comb begin
		msb = (bit_q == smf_pkg::BIT_W'(smf_pkg::SAMPLE_W - 1));
		for (int i = 0; i < smf_pkg::MAX_WINDOW; i++) begin
			col[i] = store_q[i][smf_pkg::SAMPLE_W-1] ^ msb;
		end
		zeros    = mask_q & ~col;
		zero_cnt = smf_pkg::count_ones(zeros);
		take0    = (rank_q < zero_cnt);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q[pos_use] <= sample_in;
		end else if (state_q == ST_RUN) begin
			for (int i = 0; i < smf_pkg::MAX_WINDOW; i++) begin
				store_q[i] <= {store_q[i][smf_pkg::SAMPLE_W-2:0],
					store_q[i][smf_pkg::SAMPLE_W-1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= mask_init;
			rank_q <= fill_next >> 1;
		end else if (state_q == ST_RUN) begin
			mask_q <= take0 ? zeros : (mask_q & col);
			rank_q <= take0 ? rank_q : rank_q - zero_cnt;
			res_q  <= {res_q[smf_pkg::SAMPLE_W-2:0], (!take0) ^ msb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= smf_pkg::WIN_RESET;
			wr_pos_q    <= '0;
			fill_q      <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				win_q <= cfg_wr_data;
			end
			if (cfg_wr_en && !accept) begin
				wr_pos_q <= '0;
				fill_q   <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wr_pos_q <= pos_next;
						fill_q   <= fill_next;
						bit_q    <= smf_pkg::BIT_W'(smf_pkg::SAMPLE_W - 1);
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					bit_q <= bit_q - smf_pkg::BIT_W'(1);
					if (bit_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			median_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign median_out = median_q;

endmodule

@@ design/smf_checker.sv @@
module smf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic signed [smf_pkg::SAMPLE_W-1:0] sample_in,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [smf_pkg::SAMPLE_W-1:0] median_out,
	input logic                              cfg_wr_en,
	input logic        [smf_pkg::CFG_W-1:0]    cfg_wr_data
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(median_out))
		else $error("stalled result changed");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still selecting");

	// one result bit per cycle: still busy while the last result bit is selected
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##15 in_stall)
		else $error("selection finished early");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in progress");

endmodule

bind sliding_median_filter_unit smf_checker u_smf_checker (.*);

@@ tb/sliding_median_filter_unit_tb.sv @@
`timescale 1ns / 100ps

module sliding_median_filter_unit_tb;

	localparam int LIMIT       = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PHASES    = 24;
	localparam int TAIL_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [smf_pkg::SAMPLE_W-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [smf_pkg::SAMPLE_W-1:0] median_out;
	logic cfg_wr_en = 1'b0;
	logic [smf_pkg::CFG_W-1:0] cfg_wr_data = '0;

	// predictor state
	logic [smf_pkg::CFG_W-1:0] win_reg;
	logic signed [smf_pkg::SAMPLE_W-1:0] hist [smf_pkg::MAX_WINDOW];
	int hist_pos;
	int hist_fill;

	logic signed [smf_pkg::SAMPLE_W-1:0] sample_q [$];
	logic signed [smf_pkg::SAMPLE_W-1:0] median_q [$];
	logic signed [smf_pkg::SAMPLE_W-1:0] exp_med;

	int send_idle = 0;
	int recv_idle = 0;
	logic hold_tgl = 1'b0;
	logic hold_ack;
	int hold_left;
	int errors = 0;
	int n_accepted = 0;
	int n_results = 0;
	int cycles = 0;

	sliding_median_filter_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_in   (sample_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.median_out  (median_out),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	function automatic int eff_window();
		if (win_reg == '0) begin
			return 1;
		end
		if (int'(win_reg) > smf_pkg::MAX_WINDOW) begin
			return smf_pkg::MAX_WINDOW;
		end
		return int'(win_reg);
	endfunction

	function automatic void clear_hist();
		hist_pos  = 0;
		hist_fill = 0;
		for (int i = 0; i < smf_pkg::MAX_WINDOW; i++) begin
			hist[i] = '0;
		end
	endfunction

	function automatic logic signed [smf_pkg::SAMPLE_W-1:0] push_and_median(
		input logic signed [smf_pkg::SAMPLE_W-1:0] s);
		int w;
		int ordered [smf_pkg::MAX_WINDOW];
		int key;
		int j;
		w = eff_window();
		if (hist_pos >= w) begin
			hist_pos = 0;
		end
		hist[hist_pos] = s;
		hist_pos++;
		if (hist_pos >= w) begin
			hist_pos = 0;
		end
		if (hist_fill < w) begin
			hist_fill++;
		end
		if (hist_fill > w) begin
			hist_fill = w;
		end
		for (int i = 0; i < hist_fill; i++) begin
			ordered[i] = int'(hist[i]);
		end
		for (int i = 1; i < hist_fill; i++) begin
			key = ordered[i];
			j = i;
			while (j > 0 && ordered[j-1] > key) begin
				ordered[j] = ordered[j-1];
				j--;
			end
			ordered[j] = key;
		end
		return smf_pkg::SAMPLE_W'(ordered[hist_fill / 2]);
	endfunction

	function automatic logic signed [smf_pkg::SAMPLE_W-1:0] gen_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			1, 2: return smf_pkg::SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
			3: begin
				if ($urandom_range(0, 1) == 0) begin
					return smf_pkg::SAMPLE_W'(32767 - int'($urandom_range(0, 3)));
				end
				return smf_pkg::SAMPLE_W'(-32768 + int'($urandom_range(0, 3)));
			end
			default: return smf_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			sample_in <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				median_q.push_back(push_and_median(sample_in));
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					in_valid  <= 1'b1;
					sample_in <= sample_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_ack  <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (median_q.size() == 0) begin
					errors++;
					$display("%0t: median %0d with no request pending", $time, median_out);
				end else begin
					exp_med = median_q.pop_front();
					if (exp_med !== median_out) begin
						errors++;
						$display("%0t: median_out expected %0d, got %0d",
							$time, exp_med, median_out);
					end
				end
			end
			if (hold_tgl != hold_ack) begin
				hold_ack  <= hold_tgl;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
		end
		$display("%0t: timeout, %0d medians outstanding", $time, median_q.size());
		$display("** sliding_median_filter_unit: FAILED **");
		$finish;
	end

	task automatic drain();
		@(negedge clk);
		while (sample_q.size() != 0 || in_valid || median_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
	endtask

	task automatic write_window(input logic [smf_pkg::CFG_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_reg = v;
		clear_hist();
		@(negedge clk);
	endtask

	initial begin
		logic [smf_pkg::CFG_W-1:0] phase_win [12];
		logic [smf_pkg::CFG_W-1:0] w;
		int n_items;
		phase_win = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd3, 5'd16, 5'd8,
			5'd15, 5'd4, 5'd24, 5'd7};
		arst_n = 1'b0;
		win_reg = smf_pkg::WIN_RESET;
		clear_hist();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, duplicates, fill and wrap of the reset window
		sample_q = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
			16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh5555, 16'shaaaa,
			16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd100, 16'sd90, 16'sd80,
			16'sd70, 16'sd60, -16'sd2, -16'sd3, 16'sd1};
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			w = (p < 12) ? phase_win[p] : smf_pkg::CFG_W'($urandom_range(0, 31));
			write_window(w);
			case (p % 3)
				0: begin
					send_idle = 36;
					recv_idle = 50;
				end
				1: begin
					send_idle = 50;
					recv_idle = 36;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			n_items = $urandom_range(40, 110);
			if (p == 7) begin
				for (int i = 0; i < n_items / 2; i++) begin
					sample_q.push_back(gen_sample());
				end
				drain();
				for (int i = n_items / 2; i < n_items; i++) begin
					sample_q.push_back(gen_sample());
				end
			end else begin
				for (int i = 0; i < n_items; i++) begin
					sample_q.push_back(gen_sample());
				end
				// long output hold-off while requests keep coming
				if (p == 4 || p == 14) begin
					hold_tgl = ~hold_tgl;
				end
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (median_q.size() != 0) begin
			errors++;
			$display("%0t: %0d medians never arrived", $time, median_q.size());
		end
		$display("Sent %0d samples and checked %0d medians over %0d window settings,",
			n_accepted, n_results, N_PHASES + 1);
		$display("including window 0, 1, 16 and above 16, with idle, stall and hold-off mixes.");
		if (errors == 0) begin
			$display("** sliding_median_filter_unit: PASSED **");
		end else begin
			$display("** sliding_median_filter_unit: FAILED **");
		end
		$finish;
	end

endmodule
